// ----- rtl/core/ksb_pkg.sv -----
// Shared types, codes and constants of the keyed slot table with billing.
`default_nettype none

package ksb_pkg;

    localparam int SLOTS_DEFAULT = 64;

    localparam logic [7:0]  FEE_RESET = 8'd5;
    localparam logic [19:0] HOURS_MAX = 20'hFFFFF;
    localparam logic [27:0] FEE_MAX   = 28'hFFFFFFF;

    // One hour is 3600 s = 16 * 225 s: a shift by four, then a reciprocal multiply.
    localparam int          SEC_SHIFT   = 4;
    localparam logic [7:0]  HOUR_DIV    = 8'd225;
    localparam int          RECIP_SHIFT = 36;
    localparam logic [28:0] RECIP_225   = 29'd305419896;

    localparam logic [1:0] ACT_ENTER       = 2'd0;
    localparam logic [1:0] ACT_LEAVE       = 2'd1;
    localparam logic [1:0] ACT_QUERY_SLOT  = 2'd2;
    localparam logic [1:0] ACT_QUERY_PLATE = 2'd3;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_FULL      = 2'd1;
    localparam logic [1:0] STS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STS_RANGE     = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] plate_low;
        logic [7:0]  plate_high;
        logic [7:0]  slot_asked;
        logic [31:0] now_seconds;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot_index;
        logic        occupied;
        logic [63:0] found_plate_low;
        logic [7:0]  found_plate_high;
        logic [19:0] hours_parked;
        logic [27:0] fee_due;
        logic [6:0]  free_slots;
    } rsp_t;

    typedef struct packed {
        logic [63:0] plate_low;
        logic [7:0]  plate_high;
        logic [31:0] entry_time;
    } entry_t;

    typedef enum logic [3:0] {
        RES_NONE,
        RES_FULL,
        RES_GRANT,
        RES_NOT_FOUND,
        RES_RANGE,
        RES_SLOT,
        RES_FOUND,
        RES_FREED,
        RES_BILL
    } res_op_t;

    typedef struct packed {
        logic    load;
        logic    scan_clear;
        logic    step;
        logic    rd_asked;
        res_op_t res_op;
        logic    publish;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       asked_bad;
        logic       ptr_end;
        logic       ptr_free;
        logic       hit;
        logic       cmp_last;
        logic       out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/ksb_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module ksb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ksb_dp.sv -----
// Datapath: request latch, slot flags, slot memory, scan pointer, billing and response register.
`default_nettype none

module ksb_dp
    import ksb_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       req_data,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data,
    input  cmd_t       cmd,
    output sts_t       sts,
    input  logic       rsp_ready,
    output logic       rsp_valid,
    output rsp_t       rsp_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = $bits(entry_t);

    req_t             req_reg;
    logic [7:0]       fee_reg;
    logic [SLOTS-1:0] used_reg;
    logic [CW-1:0]    free_reg;
    logic [CW-1:0]    ptr_reg;
    logic             cmp_valid_reg;
    logic [IW-1:0]    cmp_idx_reg;
    rsp_t             res_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_data_reg;

    logic [31:0]      elapsed_reg;
    logic [20:0]      q_est_reg;
    logic [28:0]      prod_reg;
    logic [20:0]      hours_reg;
    logic [28:0]      fee_prod_reg;

    logic [IW-1:0]    ptr_idx;
    logic [IW-1:0]    asked_idx;
    logic [7:0]       ptr_wide;
    logic [7:0]       cmp_wide;
    logic [8:0]       free_wide;
    entry_t           rd_entry;
    entry_t           wr_entry;
    logic [EW-1:0]    rd_bits;
    logic [IW-1:0]    raddr;
    logic             ram_we;
    logic             plate_eq;
    logic             ptr_end;
    rsp_t             rsp_pub;

    logic [27:0]      q1;
    logic [56:0]      recip_prod;
    logic [28:0]      rem_full;
    logic [8:0]       rem;
    logic             rem_big;
    logic [8:0]       rem_fix;
    logic             frac;
    logic [20:0]      q_est_next;
    logic [28:0]      prod_next;
    logic [20:0]      hours_next;
    logic [28:0]      fee_prod_next;
    logic [19:0]      hours_sat;
    logic [27:0]      fee_sat;

    assign ptr_idx   = ptr_reg[IW-1:0];
    assign asked_idx = req_reg.slot_asked[IW-1:0];
    assign ptr_wide  = 8'(ptr_idx);
    assign cmp_wide  = 8'(cmp_idx_reg);
    assign free_wide = 9'(free_reg);
    assign ptr_end   = (ptr_reg == CW'(SLOTS));

    assign wr_entry.plate_low  = req_reg.plate_low;
    assign wr_entry.plate_high = req_reg.plate_high;
    assign wr_entry.entry_time = req_reg.now_seconds;

    assign ram_we   = (cmd.res_op == RES_GRANT);
    assign raddr    = cmd.rd_asked ? asked_idx : ptr_idx;
    assign rd_entry = entry_t'(rd_bits);

    ksb_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_idx),
        .wdata (EW'(wr_entry)),
        .raddr (raddr),
        .rdata (rd_bits)
    );

    assign plate_eq = (rd_entry.plate_low == req_reg.plate_low)
                   && (rd_entry.plate_high == req_reg.plate_high);

    // The read data always belongs to the slot addressed in the previous cycle.
    assign sts.action    = req_reg.action;
    assign sts.asked_bad = ({1'b0, req_reg.slot_asked} >= 9'(SLOTS));
    assign sts.ptr_end   = ptr_end;
    assign sts.ptr_free  = !ptr_end && !used_reg[ptr_idx];
    assign sts.hit       = cmp_valid_reg && used_reg[cmp_idx_reg] && plate_eq;
    assign sts.cmp_last  = cmp_valid_reg && (cmp_idx_reg == IW'(SLOTS - 1));
    assign sts.out_free  = !rsp_valid_reg || rsp_ready;

    // Ceiling of elapsed / 3600: estimate the quotient of (elapsed >> 4) by 225,
    // which is low by at most one, then fix it from the remainder.
    assign q1            = elapsed_reg[31:SEC_SHIFT];
    assign recip_prod    = 57'(q1) * 57'(RECIP_225);
    assign q_est_next    = recip_prod[RECIP_SHIFT+20:RECIP_SHIFT];
    assign prod_next     = 29'(q_est_reg) * 29'(HOUR_DIV);
    assign rem_full      = {1'b0, q1} - prod_reg;
    assign rem           = rem_full[8:0];
    assign rem_big       = (rem >= 9'(HOUR_DIV));
    assign rem_fix       = rem_big ? (rem - 9'(HOUR_DIV)) : rem;
    assign frac          = (rem_fix != 9'd0) || (elapsed_reg[SEC_SHIFT-1:0] != '0);
    assign hours_next    = q_est_reg + 21'(rem_big) + 21'(frac);
    assign fee_prod_next = 29'(hours_reg) * 29'(fee_reg);
    assign hours_sat     = (hours_reg > 21'(HOURS_MAX)) ? HOURS_MAX : hours_reg[19:0];
    assign fee_sat       = (fee_prod_reg > 29'(FEE_MAX)) ? FEE_MAX : fee_prod_reg[27:0];

    always_comb
    begin
        rsp_pub            = res_reg;
        rsp_pub.free_slots = free_wide[6:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fee_reg       <= FEE_RESET;
            used_reg      <= '0;
            free_reg      <= CW'(SLOTS);
            ptr_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fee_reg <= cfg_data;
            end

            if (cmd.res_op == RES_GRANT)
            begin
                used_reg[ptr_idx] <= 1'b1;
                if (free_reg != '0)
                begin
                    free_reg <= free_reg - 1'b1;
                end
            end
            else if (cmd.res_op == RES_FREED)
            begin
                used_reg[cmp_idx_reg] <= 1'b0;
                if (free_reg != CW'(SLOTS))
                begin
                    free_reg <= free_reg + 1'b1;
                end
            end

            if (cmd.scan_clear)
            begin
                ptr_reg       <= '0;
                cmp_valid_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                cmp_valid_reg <= !ptr_end;
                if (!ptr_end)
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end

            if (cmd.publish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_est_reg    <= q_est_next;
        prod_reg     <= prod_next;
        hours_reg    <= hours_next;
        fee_prod_reg <= fee_prod_next;

        if (cmd.load)
        begin
            req_reg <= req_data;
        end

        if (cmd.step)
        begin
            cmp_idx_reg <= ptr_idx;
        end

        if (cmd.res_op == RES_FREED)
        begin
            elapsed_reg <= req_reg.now_seconds - rd_entry.entry_time;
        end

        if (cmd.publish)
        begin
            rsp_data_reg <= rsp_pub;
        end

        if (cmd.load)
        begin
            res_reg <= '0;
        end
        else
        begin
            unique case (cmd.res_op)
                RES_NONE:
                begin
                end
                RES_FULL:
                begin
                    res_reg.status <= STS_FULL;
                end
                RES_GRANT:
                begin
                    res_reg.slot_index <= ptr_wide[5:0];
                    res_reg.occupied   <= 1'b1;
                end
                RES_NOT_FOUND:
                begin
                    res_reg.status <= STS_NOT_FOUND;
                end
                RES_RANGE:
                begin
                    res_reg.status     <= STS_RANGE;
                    res_reg.slot_index <= req_reg.slot_asked[5:0];
                end
                RES_SLOT:
                begin
                    res_reg.slot_index <= req_reg.slot_asked[5:0];
                    res_reg.occupied   <= used_reg[asked_idx];
                    if (used_reg[asked_idx])
                    begin
                        res_reg.found_plate_low  <= rd_entry.plate_low;
                        res_reg.found_plate_high <= rd_entry.plate_high;
                    end
                end
                RES_FOUND:
                begin
                    res_reg.slot_index       <= cmp_wide[5:0];
                    res_reg.occupied         <= 1'b1;
                    res_reg.found_plate_low  <= rd_entry.plate_low;
                    res_reg.found_plate_high <= rd_entry.plate_high;
                end
                RES_FREED:
                begin
                    res_reg.slot_index <= cmp_wide[5:0];
                end
                RES_BILL:
                begin
                    res_reg.hours_parked <= hours_sat;
                    res_reg.fee_due      <= fee_sat;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ksb_ctrl.sv -----
// Controller: sequences one request through scan, billing and response hand-off.
`default_nettype none

module ksb_ctrl
    import ksb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_START  = 4'd1;
    localparam logic [3:0] ST_FREE   = 4'd2;
    localparam logic [3:0] ST_PLATE  = 4'd3;
    localparam logic [3:0] ST_SLOT   = 4'd4;
    localparam logic [3:0] ST_DIV_Q  = 4'd5;
    localparam logic [3:0] ST_DIV_P  = 4'd6;
    localparam logic [3:0] ST_DIV_H  = 4'd7;
    localparam logic [3:0] ST_DIV_F  = 4'd8;
    localparam logic [3:0] ST_BILL   = 4'd9;
    localparam logic [3:0] ST_FINISH = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.res_op = RES_NONE;
        state_next = state_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                unique case (sts.action)
                    ACT_ENTER:
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next     = ST_FREE;
                    end
                    ACT_LEAVE, ACT_QUERY_PLATE:
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next     = ST_PLATE;
                    end
                    ACT_QUERY_SLOT:
                    begin
                        if (sts.asked_bad)
                        begin
                            cmd.res_op = RES_RANGE;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cmd.rd_asked = 1'b1;
                            state_next   = ST_SLOT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_FREE:
            begin
                priority if (sts.ptr_end)
                begin
                    cmd.res_op = RES_FULL;
                    state_next = ST_FINISH;
                end
                else if (sts.ptr_free)
                begin
                    cmd.res_op = RES_GRANT;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_PLATE:
            begin
                // Reads run one slot ahead of the compare.
                priority if (sts.hit)
                begin
                    if (sts.action == ACT_LEAVE)
                    begin
                        cmd.res_op = RES_FREED;
                        state_next = ST_DIV_Q;
                    end
                    else
                    begin
                        cmd.res_op = RES_FOUND;
                        state_next = ST_FINISH;
                    end
                end
                else if (sts.cmp_last)
                begin
                    cmd.res_op = RES_NOT_FOUND;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_SLOT:
            begin
                cmd.res_op = RES_SLOT;
                state_next = ST_FINISH;
            end
            ST_DIV_Q:
            begin
                state_next = ST_DIV_P;
            end
            ST_DIV_P:
            begin
                state_next = ST_DIV_H;
            end
            ST_DIV_H:
            begin
                state_next = ST_DIV_F;
            end
            ST_DIV_F:
            begin
                state_next = ST_BILL;
            end
            ST_BILL:
            begin
                cmd.res_op = RES_BILL;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/keyed_slot_table_with_billing_top.sv -----
// Top level of the keyed slot table with billing: controller, datapath and assertions.
`default_nettype none

// Parking slot table keyed by a nine-character plate, handling one request at a
// time. Enter scans the slot flags one slot per cycle for the lowest free slot and
// grants it, or reports the table full. Leave and plate query scan the slot
// memory through its single read port, one slot per cycle, and stop at the
// lowest matching slot or report not found; leave then runs the hour and fee
// arithmetic. Slot query reads the asked slot without a scan, or reports a range
// error for a slot past the table. A finished response sits in the output
// register, so the next request is taken while it waits. Plate and entry-time
// storage is not cleared at reset; the table is usable right after reset, and the
// fee register may be written at any time while no request is in flight.
module keyed_slot_table_with_billing_top
    import ksb_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req_data,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    ksb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ksb_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while the previous one is still in work");

    a_publish_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> sts.out_free)
        else $error("response register overwritten before it was taken");

    a_grant_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_op == RES_GRANT) |-> sts.ptr_free)
        else $error("slot granted that is occupied or out of range");

    a_free_on_leave_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_op == RES_FREED) |-> (sts.hit && (sts.action == ACT_LEAVE)))
        else $error("slot freed without a matching leave request");
`endif

endmodule

`default_nettype wire

// ----- test/keyed_slot_table_with_billing_top_tb.sv -----
// Self-checking testbench for the keyed slot table with billing.
`timescale 1ns / 100ps

module keyed_slot_table_with_billing_top_tb
    import ksb_pkg::*;
();

    localparam int NUM_SLOTS        = SLOTS_DEFAULT;
    localparam int SECONDS_PER_HOUR = 3600;
    localparam int PLATE_POOL       = 8;
    localparam int HOLD_CYCLES      = 600;
    localparam int QUIET_LIMIT      = 5000;
    localparam int SETTLE_CYCLES    = 100;
    localparam int PHASE_ITEMS      = 290;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       req_valid;
    logic       req_ready;
    req_t       req_data;
    logic       rsp_valid;
    logic       rsp_ready;
    rsp_t       rsp_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    // Predicted table contents and fee register.
    logic        park_used       [NUM_SLOTS];
    logic [63:0] park_plate_low  [NUM_SLOTS];
    logic [7:0]  park_plate_high [NUM_SLOTS];
    logic [31:0] park_entry      [NUM_SLOTS];
    int          free_left;
    logic [7:0]  fee_rate;

    rsp_t        pending_responses[$];
    int          mismatches;
    int          quiet_cycles;
    bit          idling_on;
    bit          hold_output;
    logic [31:0] clock_now;
    logic [63:0] pool_low  [PLATE_POOL];
    logic [7:0]  pool_high [PLATE_POOL];

    keyed_slot_table_with_billing_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int lowest_match(input logic [63:0] lo, input logic [7:0] hi);
        int i;
        for (i = 0; i < NUM_SLOTS; i++)
        begin
            if (park_used[i] && park_plate_low[i] == lo && park_plate_high[i] == hi)
                return i;
        end
        return -1;
    endfunction

    // Computes the response to one request and applies its effect on the table.
    task automatic predict_response(input req_t rq, output rsp_t rs);
        int          i;
        int          hit;
        logic [31:0] elapsed;
        logic [63:0] hours;
        logic [63:0] charge;
        rs  = '0;
        hit = -1;
        case (rq.action)
            ACT_ENTER:
            begin
                for (i = NUM_SLOTS - 1; i >= 0; i--)
                begin
                    if (!park_used[i])
                        hit = i;
                end
                if (hit < 0)
                    rs.status = STS_FULL;
                else
                begin
                    park_used[hit]       = 1'b1;
                    park_plate_low[hit]  = rq.plate_low;
                    park_plate_high[hit] = rq.plate_high;
                    park_entry[hit]      = rq.now_seconds;
                    free_left--;
                    rs.slot_index = 6'(hit);
                    rs.occupied   = 1'b1;
                end
            end
            ACT_LEAVE:
            begin
                hit = lowest_match(rq.plate_low, rq.plate_high);
                if (hit < 0)
                    rs.status = STS_NOT_FOUND;
                else
                begin
                    elapsed = rq.now_seconds - park_entry[hit];
                    hours   = (64'(elapsed) + SECONDS_PER_HOUR - 1) / SECONDS_PER_HOUR;
                    charge  = hours * 64'(fee_rate);
                    rs.hours_parked = (hours > 64'(HOURS_MAX)) ? HOURS_MAX : hours[19:0];
                    rs.fee_due      = (charge > 64'(FEE_MAX)) ? FEE_MAX : charge[27:0];
                    rs.slot_index   = 6'(hit);
                    park_used[hit]  = 1'b0;
                    free_left++;
                end
            end
            ACT_QUERY_SLOT:
            begin
                rs.slot_index = rq.slot_asked[5:0];
                if (rq.slot_asked >= NUM_SLOTS)
                    rs.status = STS_RANGE;
                else if (park_used[rq.slot_asked])
                begin
                    rs.occupied         = 1'b1;
                    rs.found_plate_low  = park_plate_low[rq.slot_asked];
                    rs.found_plate_high = park_plate_high[rq.slot_asked];
                end
            end
            default:
            begin
                hit = lowest_match(rq.plate_low, rq.plate_high);
                if (hit < 0)
                    rs.status = STS_NOT_FOUND;
                else
                begin
                    rs.slot_index       = 6'(hit);
                    rs.occupied         = 1'b1;
                    rs.found_plate_low  = park_plate_low[hit];
                    rs.found_plate_high = park_plate_high[hit];
                end
            end
        endcase
        rs.free_slots = 7'(free_left);
    endtask

    function automatic req_t make_request(input logic [1:0] action, input logic [63:0] lo,
                                          input logic [7:0] hi, input logic [7:0] asked,
                                          input logic [31:0] now);
        req_t rq;
        rq.action      = action;
        rq.plate_low   = lo;
        rq.plate_high  = hi;
        rq.slot_asked  = asked;
        rq.now_seconds = now;
        return rq;
    endfunction

    // A random occupied slot, or -1 when the table is empty.
    function automatic int pick_parked_slot();
        int start;
        int i;
        start = $urandom_range(0, NUM_SLOTS - 1);
        for (i = 0; i < NUM_SLOTS; i++)
        begin
            if (park_used[(start + i) % NUM_SLOTS])
                return (start + i) % NUM_SLOTS;
        end
        return -1;
    endfunction

    // Offers one request and records its predicted response once it is accepted.
    // The valid stays high after acceptance so that back-to-back requests need no gap.
    task automatic send_request(input req_t rq);
        int   gap;
        rsp_t want;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= rq;
        do @(posedge clk); while (req_ready !== 1'b1);
        predict_response(rq, want);
        pending_responses.push_back(want);
    endtask

    task automatic drain_responses();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_fee(input logic [7:0] value);
        drain_responses();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        fee_rate = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic make_random_request(input int enter_share, output req_t rq);
        int roll;
        int s;
        rq = make_request(ACT_QUERY_SLOT, {$urandom, $urandom}, 8'($urandom), 8'($urandom), 0);
        case ($urandom_range(0, 3))
            0:       clock_now = clock_now + 32'($urandom_range(0, 900));
            1:       clock_now = clock_now + 32'($urandom_range(0, 40000));
            2:       clock_now = clock_now + 32'(SECONDS_PER_HOUR * $urandom_range(0, 100));
            default: clock_now = clock_now + $urandom;
        endcase
        roll = $urandom_range(0, 99);
        if (roll < enter_share)
        begin
            rq.action = ACT_ENTER;
            // Reusing a few plates makes duplicate entries common.
            if ($urandom_range(0, 9) < 7)
            begin
                s = $urandom_range(0, PLATE_POOL - 1);
                rq.plate_low  = pool_low[s];
                rq.plate_high = pool_high[s];
            end
        end
        else if (roll < enter_share + 37)
        begin
            rq.action = (roll < enter_share + 25) ? ACT_LEAVE : ACT_QUERY_PLATE;
            s = pick_parked_slot();
            if (s >= 0 && $urandom_range(0, 9) != 0)
            begin
                rq.plate_low  = park_plate_low[s];
                rq.plate_high = park_plate_high[s];
                // Land on or next to a whole hour after the entry time.
                if (rq.action == ACT_LEAVE && $urandom_range(0, 3) == 0)
                    clock_now = park_entry[s] + 32'(SECONDS_PER_HOUR * $urandom_range(0, 30))
                                + 32'($urandom_range(0, 2)) - 32'd1;
            end
        end
        else if (roll >= 95)
            rq.action = 2'($urandom);
        else if ($urandom_range(0, 3) != 0)
            rq.slot_asked = 8'($urandom_range(0, NUM_SLOTS - 1));
        rq.now_seconds = clock_now;
    endtask

    task automatic test_range_query();
        send_request(make_request(ACT_QUERY_SLOT, '0, '0, 8'(NUM_SLOTS), '0));
        send_request(make_request(ACT_QUERY_SLOT, '1, '1, 8'hFF, '1));
    endtask

    // Writing every slot first also keeps later scans away from unwritten entries.
    task automatic test_fill_to_full();
        int i;
        send_request(make_request(ACT_ENTER, '1, 8'hFF, 8'h00, 32'hFFFF_FFFF));
        send_request(make_request(ACT_ENTER, '0, 8'h00, 8'hFF, 32'd0));
        for (i = 2; i < NUM_SLOTS; i++)
            send_request(make_request(ACT_ENTER, {$urandom, $urandom}, 8'($urandom),
                                      8'($urandom), $urandom));
        send_request(make_request(ACT_ENTER, {$urandom, $urandom}, 8'($urandom), '0, $urandom));
        send_request(make_request(ACT_QUERY_PLATE, park_plate_low[NUM_SLOTS - 1],
                                  park_plate_high[NUM_SLOTS - 1], '0, '0));
    endtask

    task automatic test_unknown_plate();
        send_request(make_request(ACT_LEAVE, {$urandom, $urandom}, 8'($urandom), '0, $urandom));
        send_request(make_request(ACT_QUERY_PLATE, {$urandom, $urandom}, 8'($urandom), '0, '0));
    endtask

    task automatic test_leave_billing();
        logic [63:0] dup_low;
        logic [7:0]  dup_high;
        dup_low  = {$urandom, $urandom};
        dup_high = 8'($urandom);
        // Entered just before the clock wrapped: 3600 s elapsed gives one hour.
        send_request(make_request(ACT_LEAVE, '1, 8'hFF, '0, 32'd3599));
        // Zero elapsed time bills nothing.
        send_request(make_request(ACT_LEAVE, '0, 8'h00, '0, 32'd0));
        send_request(make_request(ACT_QUERY_SLOT, '0, '0, 8'd0, '0));
        send_request(make_request(ACT_ENTER, dup_low, dup_high, '0, 32'd1000));
        send_request(make_request(ACT_ENTER, dup_low, dup_high, '0, 32'd1000));
        send_request(make_request(ACT_QUERY_PLATE, dup_low, dup_high, '0, '0));
        send_request(make_request(ACT_LEAVE, dup_low, dup_high, '0, 32'd4601));
        send_request(make_request(ACT_QUERY_PLATE, dup_low, dup_high, '0, '0));
        send_request(make_request(ACT_LEAVE, dup_low, dup_high, '0, 32'd8200));
        send_request(make_request(ACT_QUERY_SLOT, '0, '0, 8'(NUM_SLOTS - 1), '0));
    endtask

    task automatic test_fee_extremes();
        logic [63:0] lo;
        lo = {$urandom, $urandom};
        // The longest stay saturates both the hours and the fee.
        write_fee(8'hFF);
        send_request(make_request(ACT_ENTER, lo, 8'h5A, '0, 32'd0));
        send_request(make_request(ACT_LEAVE, lo, 8'h5A, '0, 32'hFFFF_FFFF));
        write_fee(8'h00);
        send_request(make_request(ACT_ENTER, lo, 8'hA5, '0, 32'd5));
        send_request(make_request(ACT_LEAVE, lo, 8'hA5, '0, 32'd7206));
        // Saturated hours but an unsaturated fee: the fee uses the true hour count.
        write_fee(8'd224);
        send_request(make_request(ACT_ENTER, lo, 8'h00, '0, 32'd0));
        send_request(make_request(ACT_LEAVE, lo, 8'h00, '0, 32'hFFFF_FFFF));
    endtask

    task automatic test_stalled_receiver();
        req_t rq;
        int   i;
        drain_responses();
        hold_output = 1'b1;
        for (i = 0; i < 12; i++)
        begin
            make_random_request(50, rq);
            send_request(rq);
        end
    endtask

    task automatic test_random_traffic();
        logic [7:0] fees [6];
        req_t       rq;
        int         p;
        int         i;
        fees = '{8'($urandom), 8'd1, 8'hFF, 8'd0, 8'($urandom), FEE_RESET};
        for (p = 0; p < 6; p++)
        begin
            write_fee(fees[p]);
            idling_on = (p != 5);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                make_random_request((p % 2 == 0) ? 50 : 22, rq);
                send_request(rq);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : response_check
        rsp_t want;
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_ready === 1'b1)
        begin
            if (pending_responses.size() == 0)
            begin
                $display("%0t: response with none expected, actual %h", $time, rsp_data);
                mismatches++;
            end
            else
            begin
                want = pending_responses.pop_front();
                check_field("status", want.status, rsp_data.status);
                check_field("slot_index", want.slot_index, rsp_data.slot_index);
                check_field("occupied", want.occupied, rsp_data.occupied);
                check_field("found_plate_low", want.found_plate_low, rsp_data.found_plate_low);
                check_field("found_plate_high", want.found_plate_high,
                            rsp_data.found_plate_high);
                check_field("hours_parked", want.hours_parked, rsp_data.hours_parked);
                check_field("fee_due", want.fee_due, rsp_data.fee_due);
                check_field("free_slots", want.free_slots, rsp_data.free_slots);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Response side: random stalls, plus one long hold-off on request.
    initial
    begin : receiver
        int n;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                hold_output = 1'b0;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 15);
                rsp_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    initial
    begin
        int i;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_data     = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        mismatches   = 0;
        quiet_cycles = 0;
        idling_on    = 1'b1;
        hold_output  = 1'b0;
        free_left    = NUM_SLOTS;
        fee_rate     = FEE_RESET;
        clock_now    = $urandom;
        for (i = 0; i < NUM_SLOTS; i++)
            park_used[i] = 1'b0;
        for (i = 0; i < PLATE_POOL; i++)
        begin
            pool_low[i]  = {$urandom, $urandom};
            pool_high[i] = 8'($urandom);
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_range_query();
        test_fill_to_full();
        test_unknown_plate();
        test_leave_billing();
        test_fee_extremes();
        test_stalled_receiver();
        test_random_traffic();

        drain_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_responses.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
